>>> rtl/core/cab_pkg.sv
package cab_pkg;

    // default sizing
    localparam int NUM_SLOTS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 4;

    // buffer count after reset, before clamping
    localparam logic [4:0] RESET_NUM_BUFFERS = 5'd16;

    // payload field widths
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 3;
    localparam int NB_CFG_W = 5;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_RESERVE = 2'd0,
        FUNC_PUT     = 2'd1,
        FUNC_GET     = 2'd2,
        FUNC_RELEASE = 2'd3
    } func_t;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NO_MSG     = 3'd2,
        ST_BAD_INDEX  = 3'd3,
        ST_COUNT_FULL = 3'd4
    } status_t;

endpackage

>>> rtl/core/cab_buffer_index_manager.sv
// channel | dir | signals                      | content
// --------+-----+------------------------------+------------------------------------
// s_      | in  | s_tvalid s_tready s_tdata    | [1:0] func, [5:2] buffer_index
// m_      | out | m_tvalid m_tready m_tdata    | [3:0] result_index, [6:4] status
// cfg_    | in  | cfg_valid cfg_ready cfg_data | [4:0] num_buffers
//
// one operation per cycle while results are taken; free stack, reader counts
// and most recent buffer update at the beat and the result sits in the output
// register the next cycle, so throughput is one beat per clock without stalls
// free stack and reader counts are flip-flop files, one read and one write each
// reset and a config write both restore the initial state for their buffer count
// when a result waits untaken, s_tready drops until m_tready takes it
module cab_buffer_index_manager #(
    parameter int NUM_SLOTS  = cab_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = cab_pkg::COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [1:0] func, [5:2] buffer_index, [7:6] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] result_index, [6:4] status, [7] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data   // [4:0] num_buffers
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = (CNT_W > cab_pkg::INDEX_W) ? CNT_W : cab_pkg::INDEX_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // clamp a requested buffer count into 2..NUM_SLOTS
    function automatic logic [CNT_W-1:0] clamp_nb(input logic [cab_pkg::NB_CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v < 5'd2)
            r = CNT_W'(2);
        else if (int'(v) > NUM_SLOTS)
            r = CNT_W'(NUM_SLOTS);
        else
            r = CNT_W'(v);
        return r;
    endfunction

    logic [CNT_W-1:0]      nb_reg;
    logic [CNT_W-1:0]      fc_reg, fc_next;
    logic [IDX_W-1:0]      li_reg, li_next;
    logic                  lv_reg, lv_next;
    logic [IDX_W-1:0]      stack_reg [NUM_SLOTS];
    logic [COUNT_BITS-1:0] cnt_reg   [NUM_SLOTS];
    logic                  m_tvalid_reg;
    logic [7:0]            m_tdata_reg, m_tdata_next;

    cab_pkg::func_t          func;
    logic [cab_pkg::INDEX_W-1:0] idx_in;
    logic [IDX_W-1:0]        idx;
    logic                    idx_ok;
    logic [IDX_W-1:0]        cnt_addr;
    logic [COUNT_BITS-1:0]   cnt_rd;
    logic                    cnt_we;
    logic [COUNT_BITS-1:0]   cnt_wval;
    logic [IDX_W-1:0]        stack_top;
    logic                    can_push;
    logic                    push;
    logic [IDX_W-1:0]        push_val;
    logic [cab_pkg::INDEX_W-1:0] res;
    cab_pkg::status_t        st;
    logic                    s_beat;
    logic                    cfg_beat;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_beat    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // operation decode and next state
    always_comb
    begin
        func      = cab_pkg::func_t'(s_tdata[1:0]);
        idx_in    = s_tdata[5:2];
        idx       = IDX_W'(idx_in);
        idx_ok    = CMP_W'(idx_in) < CMP_W'(nb_reg);
        cnt_addr  = (func == cab_pkg::FUNC_RELEASE) ? idx : li_reg;
        cnt_rd    = cnt_reg[cnt_addr];
        stack_top = stack_reg[IDX_W'(fc_reg - 1'b1)];
        can_push  = fc_reg < nb_reg;

        res      = '0;
        st       = cab_pkg::ST_OK;
        push     = 1'b0;
        push_val = idx;
        fc_next  = fc_reg;
        li_next  = li_reg;
        lv_next  = lv_reg;
        cnt_we   = 1'b0;
        cnt_wval = cnt_rd;

        case (func)
            cab_pkg::FUNC_RESERVE:
            begin
                if (fc_reg == '0)
                    st = cab_pkg::ST_EMPTY;
                else
                begin
                    fc_next = fc_reg - 1'b1;
                    res     = cab_pkg::INDEX_W'(stack_top);
                end
            end
            cab_pkg::FUNC_PUT:
            begin
                if (!idx_ok)
                    st = cab_pkg::ST_BAD_INDEX;
                else
                begin
                    // old most recent goes back if nobody reads it
                    if (lv_reg && li_reg != idx && cnt_rd == '0)
                    begin
                        push     = 1'b1;
                        push_val = li_reg;
                    end
                    li_next = idx;
                    lv_next = 1'b1;
                end
            end
            cab_pkg::FUNC_GET:
            begin
                if (!lv_reg)
                    st = cab_pkg::ST_NO_MSG;
                else if (cnt_rd == COUNT_MAX)
                    st = cab_pkg::ST_COUNT_FULL;
                else
                begin
                    cnt_we   = 1'b1;
                    cnt_wval = cnt_rd + 1'b1;
                    res      = cab_pkg::INDEX_W'(li_reg);
                end
            end
            default:
            begin
                if (!idx_ok || cnt_rd == '0)
                    st = cab_pkg::ST_BAD_INDEX;
                else
                begin
                    cnt_we   = 1'b1;
                    cnt_wval = cnt_rd - 1'b1;
                    // last reader of a stale buffer frees it
                    if (cnt_rd == COUNT_BITS'(1) && !(lv_reg && li_reg == idx))
                        push = 1'b1;
                end
            end
        endcase

        // a push beyond the buffer count is dropped
        if (push && can_push)
            fc_next = fc_reg + 1'b1;
        else
            push = 1'b0;

        m_tdata_next = {1'b0, st, res};
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg       <= clamp_nb(cab_pkg::RESET_NUM_BUFFERS);
            fc_reg       <= clamp_nb(cab_pkg::RESET_NUM_BUFFERS);
            li_reg       <= '0;
            lv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                stack_reg[i] <= IDX_W'(i);
                cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_beat)
            begin
                // reinitialize all buffer state for the new buffer count
                nb_reg <= clamp_nb(cfg_data);
                fc_reg <= clamp_nb(cfg_data);
                li_reg <= '0;
                lv_reg <= 1'b0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    stack_reg[i] <= IDX_W'(i);
                    cnt_reg[i]   <= '0;
                end
            end
            else if (s_beat)
            begin
                fc_reg <= fc_next;
                li_reg <= li_next;
                lv_reg <= lv_next;
                if (push)
                    stack_reg[IDX_W'(fc_reg)] <= push_val;
                if (cnt_we)
                    cnt_reg[cnt_addr] <= cnt_wval;
            end

            // output register handshake
            if (s_beat)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s_beat)
            m_tdata_reg <= m_tdata_next;
    end

endmodule

>>> rtl/core/cab_checker.sv
module cab_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // every accepted beat gives a result the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

    // an error never carries an index
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[6:4] != cab_pkg::ST_OK) |-> m_tdata[3:0] == 4'd0)
        else $error("error result with nonzero index");

    // put and release return index zero
    a_put_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[1:0] == cab_pkg::FUNC_PUT ||
        s_tdata[1:0] == cab_pkg::FUNC_RELEASE) |=> m_tdata[3:0] == 4'd0)
        else $error("put or release returned an index");

endmodule

bind cab_buffer_index_manager cab_checker u_cab_checker (.*);

>>> test/tb.sv
module tb;
    import cab_pkg::*;

    localparam int POOL_MAX  = NUM_SLOTS_DEF;
    localparam int READS_MAX = (1 << COUNT_BITS_DEF) - 1;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        status_t            status;
    } cab_reply_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [1:0] func, [5:2] buffer_index, [7:6] zero
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;    // [3:0] result_index, [6:4] status, [7] zero
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;   // [4:0] num_buffers

    // shadow copy of the index manager state
    logic [INDEX_W-1:0] free_stk [POOL_MAX];
    logic [4:0]         free_cnt;
    logic [3:0]         readers [POOL_MAX];
    logic [INDEX_W-1:0] latest_idx;
    logic               latest_ok;
    logic [4:0]         pool_size;

    cab_reply_t awaited_replies[$];
    int         err_count = 0;
    int         stall_left = 0;
    logic       quiet = 1'b0;

    cab_buffer_index_manager DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // pool reinit on reset or register write, count clamped to 2..16
    task automatic reinit_pool(input logic [4:0] value);
        if (value < 2)
            pool_size = 5'd2;
        else if (value > POOL_MAX)
            pool_size = 5'(POOL_MAX);
        else
            pool_size = value;
        for (int i = 0; i < POOL_MAX; i++)
        begin
            free_stk[i] = INDEX_W'(i);
            readers[i]  = '0;
        end
        free_cnt   = pool_size;
        latest_idx = '0;
        latest_ok  = 1'b0;
    endtask

    // push onto the free stack, dropped when the stack is already full
    task automatic free_push(input logic [INDEX_W-1:0] idx);
        if (free_cnt < pool_size && free_cnt < POOL_MAX)
        begin
            free_stk[free_cnt[3:0]] = idx;
            free_cnt++;
        end
    endtask

    // next index-manager answer for one operation, state updated in place
    task automatic predict_cab_op(input func_t f, input logic [INDEX_W-1:0] idx,
                                  output logic [INDEX_W-1:0] res, output status_t st);
        res = '0;
        st  = ST_OK;
        case (f)
            FUNC_RESERVE:
                if (free_cnt == 0 || free_cnt > POOL_MAX)
                    st = ST_EMPTY;
                else
                begin
                    free_cnt--;
                    res = free_stk[free_cnt[3:0]];
                end
            FUNC_PUT:
                if (idx >= pool_size)
                    st = ST_BAD_INDEX;
                else
                begin
                    if (latest_ok && latest_idx != idx && readers[latest_idx] == 0)
                        free_push(latest_idx);
                    latest_idx = idx;
                    latest_ok  = 1'b1;
                end
            FUNC_GET:
                if (!latest_ok)
                    st = ST_NO_MSG;
                else if (readers[latest_idx] >= READS_MAX)
                    st = ST_COUNT_FULL;
                else
                begin
                    readers[latest_idx]++;
                    res = latest_idx;
                end
            default:
                if (idx >= pool_size || readers[idx] == 0)
                    st = ST_BAD_INDEX;
                else
                begin
                    readers[idx]--;
                    if (readers[idx] == 0 && !(latest_ok && latest_idx == idx))
                        free_push(idx);
                end
        endcase
    endtask

    // one operation beat, expectation queued at acceptance
    task automatic send_op(input func_t f, input logic [INDEX_W-1:0] idx,
                           output logic [INDEX_W-1:0] res, output status_t st);
        int         gap;
        cab_reply_t want;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, f};
        do
            @(posedge clk);
        while (!s_tready);
        predict_cab_op(f, idx, res, st);
        want.index  = res;
        want.status = st;
        awaited_replies.push_back(want);
    endtask

    // stop sending and let every outstanding answer come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_num_buffers(input logic [4:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reinit_pool(value);
        @(posedge clk);
    endtask

    // result side stalls
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < 30)
        begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        cab_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_replies.size() == 0)
                report_mismatch("unexpected beat", int'(m_tdata), 0);
            else
            begin
                want = awaited_replies.pop_front();
                if (m_tdata[3:0] !== want.index)
                    report_mismatch("result_index", int'(m_tdata[3:0]), int'(want.index));
                if (m_tdata[6:4] !== want.status)
                    report_mismatch("status", int'(m_tdata[6:4]), int'(want.status));
            end
        end
    end

    // pool of 16 straight out of reset
    task automatic test_reset_state();
        logic [INDEX_W-1:0] res;
        status_t            st;
        send_op(FUNC_GET, 4'd0, res, st);       // nothing published
        send_op(FUNC_RELEASE, 4'd0, res, st);   // release without readers
        send_op(FUNC_RESERVE, 4'd9, res, st);
        send_op(FUNC_PUT, 4'd15, res, st);
        send_op(FUNC_GET, 4'd0, res, st);
        send_op(FUNC_RELEASE, 4'd15, res, st);  // latest stays allocated
        send_op(FUNC_PUT, 4'd15, res, st);      // republish same buffer
        send_op(FUNC_PUT, 4'd0, res, st);       // previous latest freed
        send_op(FUNC_RESERVE, 4'd0, res, st);
    endtask

    // two buffers: full free list, empty free list, bad indices
    task automatic test_small_pool();
        logic [INDEX_W-1:0] res;
        status_t            st;
        write_num_buffers(5'd2);
        send_op(FUNC_PUT, 4'd0, res, st);
        send_op(FUNC_PUT, 4'd1, res, st);       // push dropped, stack already full
        send_op(FUNC_RESERVE, 4'd15, res, st);
        send_op(FUNC_RESERVE, 4'd0, res, st);
        send_op(FUNC_RESERVE, 4'd0, res, st);   // free list empty
        send_op(FUNC_PUT, 4'd2, res, st);
        send_op(FUNC_PUT, 4'd15, res, st);
        send_op(FUNC_RELEASE, 4'd3, res, st);
    endtask

    // reader counter runs into its ceiling, back to back
    task automatic test_reader_saturation();
        logic [INDEX_W-1:0] res;
        status_t            st;
        write_num_buffers(5'd16);
        quiet = 1'b1;
        send_op(FUNC_PUT, 4'd3, res, st);
        repeat (READS_MAX + 1)
            send_op(FUNC_GET, 4'd0, res, st);
        send_op(FUNC_RELEASE, 4'd3, res, st);
        quiet = 1'b0;
    endtask

    // register values outside 2..16 are clamped
    task automatic test_config_clamp();
        logic [INDEX_W-1:0] res;
        status_t            st;
        write_num_buffers(5'd0);
        send_op(FUNC_RESERVE, 4'd0, res, st);
        send_op(FUNC_PUT, 4'd15, res, st);
        write_num_buffers(5'd31);
        send_op(FUNC_RESERVE, 4'd0, res, st);
        send_op(FUNC_PUT, 4'd15, res, st);
        write_num_buffers(5'd17);
        send_op(FUNC_RESERVE, 4'd0, res, st);
        write_num_buffers(5'd1);
        send_op(FUNC_RESERVE, 4'd0, res, st);
    endtask

    // writer and reader cycles with random content, plus some noise
    task automatic test_random_traffic();
        logic [4:0]         settings [6];
        logic [INDEX_W-1:0] res;
        logic [INDEX_W-1:0] slot;
        logic [INDEX_W-1:0] held [$];
        status_t            st;
        int                 sent;
        int                 pick;
        int                 k;
        int                 p;
        settings = '{5'd16, 5'd2, 5'd3, 5'd9, 5'd31, 5'd0};
        settings[3] = 5'($urandom_range(0, 31));
        settings[5] = 5'($urandom_range(2, 16));
        for (p = 0; p < 6; p++)
        begin
            write_num_buffers(settings[p]);
            held.delete();
            quiet = (p == 2);
            sent  = 0;
            while (sent < 220)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    send_op(FUNC_RESERVE, 4'($urandom), res, st);
                    sent++;
                    if (st == ST_OK && $urandom_range(0, 9) != 0)
                    begin
                        slot = res;
                        send_op(FUNC_PUT, slot, res, st);
                        sent++;
                    end
                end
                else if (pick < 65 || held.size() == 0)
                begin
                    send_op(FUNC_GET, 4'($urandom), res, st);
                    sent++;
                    if (st == ST_OK)
                        held.push_back(res);
                end
                else if (pick < 90)
                begin
                    k = $urandom_range(0, held.size() - 1);
                    send_op(FUNC_RELEASE, held[k], res, st);
                    held.delete(k);
                    sent++;
                end
                else
                begin
                    send_op(func_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), res, st);
                    sent++;
                end
            end
            quiet = 1'b0;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        reinit_pool(RESET_NUM_BUFFERS);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_small_pool();
        test_reader_saturation();
        test_config_clamp();
        test_random_traffic();

        wait_idle();
        repeat (5) @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/cab_pkg.sv
rtl/core/cab_buffer_index_manager.sv
rtl/core/cab_checker.sv
test/tb.sv
